@@ rtl/lirc_pkg.sv @@
// Package: payload types, register indexes and constants of the rate converter
package lirc_pkg;

  localparam int MaxChannels = 8;
  localparam int SampleW     = 16;
  localparam int RateW       = 20;
  localparam int CountW      = 4;
  localparam int TimeW       = 64;
  localparam int MaxResults  = 64;
  // product of a sample and a rate-sized weight, plus two guard bits
  localparam int MixW        = SampleW + RateW + 2;

  localparam logic [1:0] RegSourceRate   = 2'd0;
  localparam logic [1:0] RegTargetRate   = 2'd1;
  localparam logic [1:0] RegChannelCount = 2'd2;

  localparam logic [RateW-1:0]  SourceRateReset   = RateW'(44100);
  localparam logic [RateW-1:0]  TargetRateReset   = RateW'(44100);
  localparam logic [CountW-1:0] ChannelCountReset = CountW'(2);

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t in_ch7;
    sample_t in_ch6;
    sample_t in_ch5;
    sample_t in_ch4;
    sample_t in_ch3;
    sample_t in_ch2;
    sample_t in_ch1;
    sample_t in_ch0;
  } in_item_t;

  typedef struct packed {
    logic    last_of_run;
    sample_t out_ch7;
    sample_t out_ch6;
    sample_t out_ch5;
    sample_t out_ch4;
    sample_t out_ch3;
    sample_t out_ch2;
    sample_t out_ch1;
    sample_t out_ch0;
  } out_item_t;

endpackage

@@ rtl/linear_interp_rate_converter.sv @@
// Top level: linear interpolation sample rate converter with bit-serial arithmetic
//
//  channel | ports                              | request carries
//  --------+------------------------------------+----------------------------------
//  input   | in_valid  in_ready  in_data        | one frame, eight signed samples
//  output  | out_valid out_ready out_data       | one output frame + last_of_run
//  config  | cfg_valid cfg_ready cfg_index/data | register index and write value
//
// A first frame is copied straight through; an equal-rate frame rebuilds frames *
// source_rate by a serial product. An interpolated frame runs two serial time
// products, then per output a check, for each of the eight lanes a setup, a serial
// weight product and a restoring division, and then an emit.
// Reset is synchronous and active low; it restores register defaults and state.
// A held output stalls the block; input is taken only once all results have left.
module linear_interp_rate_converter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lirc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lirc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);
  import lirc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TMUL  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_LANE  = 8'b0000_1000,
    ST_MUL   = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_EMIT  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  localparam int DivW  = MixW;
  localparam int TCntW = $clog2(TimeW + 1);
  localparam int MCntW = $clog2(RateW + 1);
  localparam int DCntW = $clog2(DivW + 1);
  localparam int LaneW = $clog2(MaxChannels);
  localparam int NCntW = $clog2(MaxResults + 1);

  state_t state_r, state_nxt;

  logic [RateW-1:0]  src_r, tgt_r;
  logic [CountW-1:0] chn_r;
  logic              primed_r;
  logic [TimeW-1:0]  frames_r, otime_r;
  sample_t           prev_r [MaxChannels];
  sample_t           cur_r  [MaxChannels];
  sample_t           res_r  [MaxChannels];
  logic              out_valid_r;
  out_item_t         out_data_r;

  // serial time product: a frame count times src_r or tgt_r (bit per cycle)
  logic [TimeW-1:0]  tacc_r, tmcand_r;
  logic [RateW-1:0]  tmplier_r;
  logic [TCntW-1:0]  tcnt_r;
  logic [TimeW-1:0]  prev_t_r, cur_t_r;
  logic              ttarget_r; // low while computing prev_t, high for cur_t (or otime at equal rates)

  // per-output state
  logic [RateW-1:0]  off_r;
  logic [NCntW-1:0]  nout_r;
  logic [LaneW-1:0]  lane_r;

  // serial multiply-accumulate and divider
  logic [MixW-1:0]   macc_r;     // magnitude-free signed accumulator
  logic [MixW-1:0]   ma_r, mb_r; // shifted multiplicands
  logic [RateW-1:0]  wa_r, wb_r; // weights consumed lsb first
  logic [MCntW-1:0]  mcnt_r;
  logic [DivW-1:0]   rem_r, quo_r, num_r;
  logic              neg_r;
  logic [DCntW-1:0]  dcnt_r;

  logic cfg_ok, equal_rates;
  assign cfg_ok = (src_r != '0) && (tgt_r != '0) && (chn_r != '0) &&
                  (chn_r <= CountW'(MaxChannels));
  assign equal_rates = (src_r == tgt_r);

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  // output payload, held in its own register while it waits
  assign out_data = out_data_r;

  // next output time, and offset from the interval start with saturation
  logic [TimeW-1:0] otime_next, off_full;
  logic             due;
  assign otime_next = otime_r + TimeW'(src_r);
  assign due        = (otime_r <= cur_t_r) && (nout_r < NCntW'(MaxResults));
  assign off_full   = (otime_r >= prev_t_r) ? (otime_r - prev_t_r) : '0;

  // divider step
  logic [DivW:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_r, num_r[DivW-1]};
  assign rem_sub = rem_sh - (DivW+1)'(tgt_r);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && cfg_ok) begin
                  if (!equal_rates && !primed_r) state_nxt = ST_DONE;
                  else state_nxt = ST_TMUL;
                end
      ST_TMUL:  if (tcnt_r == TCntW'(TimeW - 1) && ttarget_r)
                  state_nxt = equal_rates ? ST_DONE : ST_CHECK;
      ST_CHECK: state_nxt = due ? ST_LANE : ST_DONE;
      ST_LANE:  state_nxt = ST_MUL;
      ST_MUL:   if (mcnt_r == MCntW'(RateW - 1)) state_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == DCntW'(DivW - 1)) begin
                  if (lane_r == LaneW'(MaxChannels - 1)) state_nxt = ST_EMIT;
                  else state_nxt = ST_LANE;
                end
      ST_EMIT:  if (!out_valid_r || out_ready) state_nxt = ST_CHECK;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // lane samples, sign-extended
  logic [MixW-1:0] pa, pb;
  assign pa = MixW'(prev_r[lane_r]);
  assign pb = MixW'(cur_r[lane_r]);
  logic [RateW-1:0] off_sat;
  assign off_sat = (off_full > TimeW'(tgt_r)) ? tgt_r : off_full[RateW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      src_r       <= SourceRateReset;
      tgt_r       <= TargetRateReset;
      chn_r       <= ChannelCountReset;
      primed_r    <= 1'b0;
      frames_r    <= '0;
      otime_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MaxChannels; i++) prev_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      // the emit state refills the output register itself
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) out_valid_r <= 1'b0;

      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          RegSourceRate:   src_r <= cfg_data[RateW-1:0];
          RegTargetRate:   tgt_r <= cfg_data[RateW-1:0];
          RegChannelCount: chn_r <= cfg_data[CountW-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: if (in_fire && cfg_ok) begin
          cur_r[0] <= in_data.in_ch0;
          cur_r[1] <= in_data.in_ch1;
          cur_r[2] <= in_data.in_ch2;
          cur_r[3] <= in_data.in_ch3;
          cur_r[4] <= in_data.in_ch4;
          cur_r[5] <= in_data.in_ch5;
          cur_r[6] <= in_data.in_ch6;
          cur_r[7] <= in_data.in_ch7;
          // equal rates: new output time is the new frame count times source;
          // otherwise the interval ends (frames-1)*target and frames*target
          tacc_r    <= '0;
          tmcand_r  <= equal_rates ? frames_r + TimeW'(1) : frames_r - TimeW'(1);
          tmplier_r <= equal_rates ? src_r : tgt_r;
          tcnt_r    <= '0;
          ttarget_r <= equal_rates;
          nout_r    <= '0;
          if (equal_rates || !primed_r) begin
            // copy straight through
            out_data_r.out_ch0     <= (chn_r > 4'd0) ? in_data.in_ch0 : '0;
            out_data_r.out_ch1     <= (chn_r > 4'd1) ? in_data.in_ch1 : '0;
            out_data_r.out_ch2     <= (chn_r > 4'd2) ? in_data.in_ch2 : '0;
            out_data_r.out_ch3     <= (chn_r > 4'd3) ? in_data.in_ch3 : '0;
            out_data_r.out_ch4     <= (chn_r > 4'd4) ? in_data.in_ch4 : '0;
            out_data_r.out_ch5     <= (chn_r > 4'd5) ? in_data.in_ch5 : '0;
            out_data_r.out_ch6     <= (chn_r > 4'd6) ? in_data.in_ch6 : '0;
            out_data_r.out_ch7     <= (chn_r > 4'd7) ? in_data.in_ch7 : '0;
            out_data_r.last_of_run <= 1'b1;
            out_valid_r <= 1'b1;
            primed_r    <= 1'b1;
            if (equal_rates) begin
              frames_r <= frames_r + TimeW'(1);
            end else begin
              frames_r <= TimeW'(1);
              otime_r  <= TimeW'(src_r);
            end
          end
        end
        ST_TMUL: begin
          // one bit of the multiplier per cycle
          if (tmplier_r[0]) tacc_r <= tacc_r + tmcand_r;
          tmcand_r  <= tmcand_r << 1;
          tmplier_r <= tmplier_r >> 1;
          if (tcnt_r == TCntW'(TimeW - 1)) begin
            tcnt_r <= '0;
            if (!ttarget_r) begin
              prev_t_r  <= tmplier_r[0] ? tacc_r + tmcand_r : tacc_r;
              tacc_r    <= '0;
              tmcand_r  <= frames_r;
              tmplier_r <= tgt_r;
              ttarget_r <= 1'b1;
            end else if (equal_rates) begin
              otime_r <= tmplier_r[0] ? tacc_r + tmcand_r : tacc_r;
            end else begin
              cur_t_r <= tmplier_r[0] ? tacc_r + tmcand_r : tacc_r;
            end
          end else begin
            tcnt_r <= tcnt_r + TCntW'(1);
          end
        end
        ST_CHECK: begin
          lane_r <= '0;
          off_r  <= off_sat;
          if (!due) begin
            // frame done; the last output already carries its flag
            for (int i = 0; i < MaxChannels; i++)
              if (CountW'(i) < chn_r) prev_r[i] <= cur_r[i];
            frames_r <= frames_r + TimeW'(1);
          end
        end
        ST_LANE: begin
          macc_r <= '0;
          ma_r   <= pa;
          mb_r   <= pb;
          wa_r   <= tgt_r - off_r;
          wb_r   <= off_r;
          mcnt_r <= '0;
        end
        ST_MUL: begin
          // prev*(span-off) + cur*off, one weight bit per cycle
          macc_r <= macc_r + (wa_r[0] ? ma_r : '0) + (wb_r[0] ? mb_r : '0);
          ma_r   <= ma_r << 1;
          mb_r   <= mb_r << 1;
          wa_r   <= wa_r >> 1;
          wb_r   <= wb_r >> 1;
          mcnt_r <= mcnt_r + MCntW'(1);
          if (mcnt_r == MCntW'(RateW - 1)) begin
            logic [MixW-1:0] fin, mag;
            fin = macc_r + (wa_r[0] ? ma_r : '0) + (wb_r[0] ? mb_r : '0);
            mag = fin[MixW-1] ? (~fin + MixW'(1)) : fin;
            neg_r  <= fin[MixW-1];
            num_r  <= mag + MixW'(tgt_r >> 1);
            rem_r  <= '0;
            quo_r  <= '0;
            dcnt_r <= '0;
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!rem_sub[DivW]) begin
            rem_r <= rem_sub[DivW-1:0];
            quo_r <= {quo_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[DivW-1:0];
            quo_r <= {quo_r[DivW-2:0], 1'b0};
          end
          num_r  <= num_r << 1;
          dcnt_r <= dcnt_r + DCntW'(1);
          if (dcnt_r == DCntW'(DivW - 1)) begin
            logic [DivW-1:0] q;
            q = {quo_r[DivW-2:0], !rem_sub[DivW]};
            if (CountW'(lane_r) < chn_r)
              res_r[lane_r] <= neg_r ? sample_t'(~q[SampleW-1:0] + SampleW'(1))
                                     : sample_t'(q[SampleW-1:0]);
            else
              res_r[lane_r] <= '0;
            lane_r <= lane_r + LaneW'(1);
          end
        end
        ST_EMIT: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          out_data_r.out_ch0 <= res_r[0];
          out_data_r.out_ch1 <= res_r[1];
          out_data_r.out_ch2 <= res_r[2];
          out_data_r.out_ch3 <= res_r[3];
          out_data_r.out_ch4 <= res_r[4];
          out_data_r.out_ch5 <= res_r[5];
          out_data_r.out_ch6 <= res_r[6];
          out_data_r.out_ch7 <= res_r[7];
          // last flag: next output not due or burst cap hit
          out_data_r.last_of_run <= !((otime_next <= cur_t_r) &&
                                      (nout_r + NCntW'(1) < NCntW'(MaxResults)));
          nout_r  <= nout_r + NCntW'(1);
          otime_r <= otime_next;
        end
        ST_DONE: begin
          for (int i = 0; i < MaxChannels; i++)
            if (CountW'(i) < chn_r) prev_r[i] <= cur_r[i];
        end
        default: ;
      endcase
    end
  end

endmodule
